FILE: rtl/isst_pkg.sv
// Shared types, constants and helper functions for the IMU scale and tilt block.
`default_nettype none
package isst_pkg;

  // Number of angle iterations run by the tilt pipeline.
  localparam int unsigned AngleIterations = 16;
  localparam int unsigned AngleLimit = 11520;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_ACCEL_RANGE = 3'd0,
    REG_GYRO_RANGE  = 3'd1,
    REG_ACC_OFS_X   = 3'd2,
    REG_ACC_OFS_Y   = 3'd3,
    REG_ACC_OFS_Z   = 3'd4,
    REG_GYR_OFS_X   = 3'd5,
    REG_GYR_OFS_Y   = 3'd6,
    REG_GYR_OFS_Z   = 3'd7
  } reg_idx_e;

  // Configuration register file contents.
  typedef struct packed {
    logic [1:0]        accel_range;
    logic [1:0]        gyro_range;
    logic signed [15:0] acc_ofs_x;
    logic signed [15:0] acc_ofs_y;
    logic signed [15:0] acc_ofs_z;
    logic signed [15:0] gyr_ofs_x;
    logic signed [15:0] gyr_ofs_y;
    logic signed [15:0] gyr_ofs_z;
  } cfg_t;

  // Arctangent table in 1/32768 degree.
  function automatic logic [20:0] atan_entry(input logic [4:0] i);
    logic [20:0] r;
    begin
      case (i)
        5'd0:  r = 21'd1474560;
        5'd1:  r = 21'd870484;
        5'd2:  r = 21'd459940;
        5'd3:  r = 21'd233473;
        5'd4:  r = 21'd117189;
        5'd5:  r = 21'd58652;
        5'd6:  r = 21'd29333;
        5'd7:  r = 21'd14667;
        5'd8:  r = 21'd7334;
        5'd9:  r = 21'd3667;
        5'd10: r = 21'd1833;
        5'd11: r = 21'd917;
        5'd12: r = 21'd458;
        5'd13: r = 21'd229;
        5'd14: r = 21'd115;
        5'd15: r = 21'd57;
        5'd16: r = 21'd29;
        5'd17: r = 21'd14;
        5'd18: r = 21'd7;
        5'd19: r = 21'd4;
        5'd20: r = 21'd2;
        5'd21: r = 21'd1;
        default: r = 21'd0;
      endcase
      return r;
    end
  endfunction

  // Saturate a 20-bit signed value to 16 bits.
  function automatic logic [15:0] sat16(input logic signed [19:0] v);
    begin
      if (v > 20'sd32767) return 16'h7fff;
      if (v < -20'sd32768) return 16'h8000;
      return v[15:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/isst_scale.sv
// Accelerometer and gyro scaling with offsets: two register stages.
`default_nettype none
module isst_scale (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire isst_pkg::cfg_t    cfg_i,
  input  wire logic [95:0]       raw_i,
  output logic [95:0]            out_o
);
  import isst_pkg::*;

  logic [45:0]        prod_q [3];
  logic               neg_q [3];
  logic signed [15:0] aacc_q [3];
  logic [15:0]        ofs_q [3];

  // Rate numerator and rounding term (divisor - 1) / 2, both premultiplied by the
  // divisor reciprocal in units of 2^-29: ceil(2^29 / 131) = 4098252 and
  // ceil(2^29 / 41) = 13094413. The product is exact for dividends below 2^21.
  logic [28:0] num_rcp;
  logic [28:0] half_rcp;

  always_comb begin
    case (cfg_i.gyro_range)
      2'd0: begin num_rcp = 29'd65572032;  half_rcp = 29'd266386380; end
      2'd1: begin num_rcp = 29'd131144064; half_rcp = 29'd266386380; end
      2'd2: begin num_rcp = 29'd261888260; half_rcp = 29'd261888260; end
      default: begin num_rcp = 29'd523776520; half_rcp = 29'd261888260; end
    endcase
  end

  // Stage one: accel shift with offset, gyro magnitude times scaled numerator.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [16:0] r;
        logic signed [17:0] rr;
        logic [16:0] mag;
        logic [1:0]  sh;
        logic signed [19:0] s;
        sh = 2'd3 - cfg_i.accel_range;
        r  = 17'(signed'(raw_i[16*k +: 16]));
        rr = (sh == 2'd0) ? 18'(r) : ((18'(r) + (18'sd1 <<< (sh - 2'd1))) >>> sh);
        s  = 20'(rr) + 20'(signed'(k == 0 ? cfg_i.acc_ofs_x :
                                    k == 1 ? cfg_i.acc_ofs_y : cfg_i.acc_ofs_z));
        aacc_q[k] <= signed'(sat16(s));
        r   = 17'(signed'(raw_i[48+16*k +: 16]));
        mag = r[16] ? 17'(-r) : 17'(r);
        neg_q[k]  <= r[16];
        prod_q[k] <= 46'(mag * num_rcp) + 46'(half_rcp);
        ofs_q[k]  <= k == 0 ? cfg_i.gyr_ofs_x : k == 1 ? cfg_i.gyr_ofs_y : cfg_i.gyr_ofs_z;
      end
    end
  end

  // Stage two: quotient from the reciprocal product, sign and bias removal.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        logic [15:0] q;
        logic signed [19:0] s;
        q = prod_q[k][44:29];
        s = (neg_q[k] ? -20'(q) : 20'(q)) - 20'(signed'(ofs_q[k]));
        out_o[48+16*k +: 16] <= sat16(s);
        out_o[16*k +: 16]    <= aacc_q[k];
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/isst_cordic.sv
// Square root of the magnitude and a pipelined vectoring CORDIC for one angle.
`default_nettype none
module isst_cordic (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] num_i,
  input  wire logic signed [15:0] a_i,
  input  wire logic signed [15:0] b_i,
  output logic signed [14:0]      ang_o
);
  import isst_pkg::*;

  localparam int unsigned Steps = (AngleIterations > 24) ? 24 : AngleIterations;
  localparam int unsigned SqStg = 25;

  // Square stage.
  logic [31:0]        sq_q;
  logic signed [15:0] n0_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= 32'(a_i * a_i) + 32'(b_i * b_i);
      n0_q <= num_i;
    end
  end

  // Restoring square root, one result bit per stage, of sq << 16.
  logic [47:0]        rem_q [SqStg];
  logic [23:0]        root_q [SqStg];
  logic signed [15:0] nr_q [SqStg];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {sq_q, 16'd0};
      root_q[0] <= '0;
      nr_q[0]   <= n0_q;
      for (int s = 1; s < SqStg; s++) begin
        logic [47:0] trial;
        logic [47:0] cand;
        // Trial term (4 * root + 1) at the weight of the bit under test.
        cand  = 48'({root_q[s-1], 2'b01}) << (2 * (24 - s));
        trial = rem_q[s-1];
        if (trial >= cand) begin
          rem_q[s]  <= trial - cand;
          root_q[s] <= {root_q[s-1][22:0], 1'b1};
        end else begin
          rem_q[s]  <= trial;
          root_q[s] <= {root_q[s-1][22:0], 1'b0};
        end
        nr_q[s] <= nr_q[s-1];
      end
    end
  end

  // CORDIC rotations, one per stage.
  logic signed [27:0] x_q [Steps+1];
  logic signed [27:0] y_q [Steps+1];
  logic signed [22:0] z_q [Steps+1];
  logic               zv_q [Steps+1];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= signed'(28'(root_q[SqStg-1]));
      y_q[0]  <= 28'(nr_q[SqStg-1]) <<< 8;
      z_q[0]  <= '0;
      zv_q[0] <= (root_q[SqStg-1] == '0) && (nr_q[SqStg-1] == '0);
      for (int i = 0; i < Steps; i++) begin
        logic signed [22:0] at;
        at = signed'(23'(atan_entry(5'(i))));
        if (!y_q[i][27]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + at;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - at;
        end
        zv_q[i+1] <= zv_q[i];
      end
    end
  end

  // Rounding to 1/128 degree and clamp.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic signed [14:0] r;
      r = 15'((z_q[Steps] + 23'sd128) >>> 8);
      if (zv_q[Steps]) ang_o <= '0;
      else if (r > 15'sd11520) ang_o <= 15'sd11520;
      else if (r < -15'sd11520) ang_o <= -15'sd11520;
      else ang_o <= r;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/imu_sample_scale_and_tilt.sv
// Top level: configuration registers, valid pipeline, scaling and tilt units.
//  channel   direction  content
//  s_axis    in         raw sample set
//  m_axis    out        calibrated sample and angles
//  cfg       in         register index and value
// One request enters per clock while the pipeline advances; there are Lat = Steps + 30
// register stages (46 with 16 iterations): two scaling, one square, 25 square root,
// one CORDIC load, Steps rotations and one rounding.
// The whole pipeline advances while the output is free or being taken.
// A stall freezes every stage; nothing is lost or repeated.
// Reset clears the valid bits and sets accel range 2, gyro range 1, zero offsets.
`default_nettype none
module imu_sample_scale_and_tilt (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,  // raw_accel_x/y/z, raw_gyro_x/y/z
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata,  // accel_x/y/z, rate_x/y/z, roll, pitch, pad
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [15:0]  cfg_data_i
);
  import isst_pkg::*;

  localparam int unsigned Steps = (AngleIterations > 24) ? 24 : AngleIterations;
  localparam int unsigned Lat = Steps + 30;

  cfg_t cfg_q;
  logic [Lat-1:0] vld_q;
  logic en;
  logic [95:0] sc_d;
  logic [95:0] sc_line_q [Lat-2];
  logic signed [14:0] roll, pitch;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = vld_q[Lat-1];

  // Register file writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{accel_range: 2'd2, gyro_range: 2'd1, default: '0};
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ACCEL_RANGE: cfg_q.accel_range <= cfg_data_i[1:0];
        REG_GYRO_RANGE:  cfg_q.gyro_range <= cfg_data_i[1:0];
        REG_ACC_OFS_X:   cfg_q.acc_ofs_x <= cfg_data_i;
        REG_ACC_OFS_Y:   cfg_q.acc_ofs_y <= cfg_data_i;
        REG_ACC_OFS_Z:   cfg_q.acc_ofs_z <= cfg_data_i;
        REG_GYR_OFS_X:   cfg_q.gyr_ofs_x <= cfg_data_i;
        REG_GYR_OFS_Y:   cfg_q.gyr_ofs_y <= cfg_data_i;
        REG_GYR_OFS_Z:   cfg_q.gyr_ofs_z <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits follow the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
  end

  isst_scale u_scale (.clk_i, .en_i(en), .cfg_i(cfg_q), .raw_i(s_axis_tdata), .out_o(sc_d));

  isst_cordic u_roll (.clk_i, .en_i(en), .num_i(sc_d[31:16]), .a_i(sc_d[15:0]),
                      .b_i(sc_d[47:32]), .ang_o(roll));
  isst_cordic u_pitch (.clk_i, .en_i(en), .num_i(sc_d[15:0]), .a_i(sc_d[31:16]),
                       .b_i(sc_d[47:32]), .ang_o(pitch));

  // Delay line for the scaled values alongside the angle pipeline.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_line_q[0] <= sc_d;
      for (int i = 1; i < Lat - 2; i++) sc_line_q[i] <= sc_line_q[i-1];
    end
  end

  assign m_axis_tdata = {2'b00, 15'(-pitch), roll, sc_line_q[Lat-3]};
endmodule
`default_nettype wire

FILE: rtl/isst_checker.sv
// Port-level checker for the IMU scale and tilt block, with its bind.
`default_nettype none
module isst_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic         s_axis_tready,
  input wire logic [127:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("out changed");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("input blocked");
  a_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[110:96]) <= 15'sd11520 &&
    $signed(m_axis_tdata[110:96]) >= -15'sd11520)) else $error("roll range");
endmodule

bind imu_sample_scale_and_tilt isst_checker u_chk (.clk_i, .rst_ni, .m_axis_tvalid,
  .m_axis_tready, .s_axis_tready, .m_axis_tdata);
`default_nettype wire
